// ===== sv/mm_pkg.sv =====
// Shared types and constants for the matrix product block.
package mm_pkg;

  localparam int IDX_W        = 4;
  localparam int ELEM_W       = 16;
  localparam int PROD_W       = 32;
  localparam int VAL_W        = 36;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int RESULT_LIMIT = 16;

  localparam int DEF_MAX_ROWS  = 16;
  localparam int DEF_MAX_INNER = 16;
  localparam int DEF_MAX_COLS  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_ROW    = 2'd2
  } cmd_t;

  // Tag that travels with each multiply term down the pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             row_last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm_tag_t;

endpackage

// ===== sv/mm_store.sv =====
// Element stores for A and B: one write and one registered read port each.
module mm_store import mm_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_INNER = DEF_MAX_INNER,
  parameter int MAX_COLS  = DEF_MAX_COLS,
  localparam int A_DEPTH  = MAX_ROWS * MAX_INNER,
  localparam int B_DEPTH  = MAX_INNER * MAX_COLS,
  localparam int A_AW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1,
  localparam int B_AW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we_a,
  input  logic [A_AW-1:0]   waddr_a,
  input  logic              we_b,
  input  logic [B_AW-1:0]   waddr_b,
  input  logic [ELEM_W-1:0] wdata,
  input  logic [A_AW-1:0]   raddr_a,
  input  logic [B_AW-1:0]   raddr_b,
  output logic [ELEM_W-1:0] rdata_a,
  output logic [ELEM_W-1:0] rdata_b
);

  logic [ELEM_W-1:0] mem_a [A_DEPTH];
  logic [ELEM_W-1:0] mem_b [B_DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr_a] <= wdata;
    end
    rdata_a <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr_b] <= wdata;
    end
    rdata_b <= mem_b[raddr_b];
  end

endmodule

// ===== sv/mm_mac.sv =====
// Multiply-accumulate pipeline: product register, accumulator and result registers.
module mm_mac import mm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mm_tag_t                 tag,
  input  logic [ELEM_W-1:0]       rdata_a,
  input  logic [ELEM_W-1:0]       rdata_b,
  output logic                    pipe_busy,
  output logic                    valid,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    row_last
);

  mm_tag_t                  tag1;
  mm_tag_t                  tag2;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  acc;
  logic signed [VAL_W-1:0]  acc_next;
  logic signed [VAL_W-1:0]  prod_ext;

  // Align the tag with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
    end else begin
      tag1.valid <= tag.valid;
      tag2.valid <= tag1.valid;
    end
    tag1.first    <= tag.first;
    tag1.last     <= tag.last;
    tag1.row_last <= tag.row_last;
    tag1.row      <= tag.row;
    tag1.col      <= tag.col;
    tag2.first    <= tag1.first;
    tag2.last     <= tag1.last;
    tag2.row_last <= tag1.row_last;
    tag2.row      <= tag1.row;
    tag2.col      <= tag1.col;
  end

  always_ff @(posedge clk) begin
    prod <= $signed(rdata_a) * $signed(rdata_b);
  end

  assign prod_ext = VAL_W'(prod);
  assign acc_next = tag2.first ? prod_ext : acc + prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      row_last <= 1'b0;
    end else begin
      valid    <= tag2.valid & tag2.last;
      row_last <= tag2.valid & tag2.last & tag2.row_last;
    end
    if (tag2.valid) begin
      acc <= acc_next;
    end
    if (tag2.valid && tag2.last) begin
      out_row <= tag2.row;
      out_col <= tag2.col;
    end
  end

  assign out_value = acc;
  assign pipe_busy = tag1.valid | tag2.valid;

endmodule

// ===== sv/mm_ctrl.sv =====
// Command decode, configuration registers and term sequencer for a row request.
module mm_ctrl import mm_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_INNER = DEF_MAX_INNER,
  parameter int MAX_COLS  = DEF_MAX_COLS,
  localparam int A_DEPTH  = MAX_ROWS * MAX_INNER,
  localparam int B_DEPTH  = MAX_INNER * MAX_COLS,
  localparam int A_AW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1,
  localparam int B_AW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1,
  localparam int LW       = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           cmd,
  input  logic [IDX_W-1:0]     row_idx,
  input  logic [IDX_W-1:0]     col_idx,
  input  logic [ELEM_W-1:0]    elem_value,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  logic [CFG_W-1:0]     wr_data,
  output logic                 we_a,
  output logic [A_AW-1:0]      waddr_a,
  output logic                 we_b,
  output logic [B_AW-1:0]      waddr_b,
  output logic [ELEM_W-1:0]    wdata,
  output logic [A_AW-1:0]      raddr_a,
  output logic [B_AW-1:0]      raddr_b,
  output mm_tag_t              tag,
  output logic                 running
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  function automatic logic [8:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
    int r;
    if (v == '0) begin
      r = 1;
    end else if (int'(v) > hi) begin
      r = hi;
    end else begin
      r = int'(v);
    end
    return 9'(r);
  endfunction

  state_t           state;
  state_t           state_next;
  logic [CFG_W-1:0] a_rows;
  logic [CFG_W-1:0] inner_len;
  logic [CFG_W-1:0] b_cols;
  logic [8:0]       rows_c;
  logic [8:0]       inner_c;
  logic [8:0]       cols_c;
  logic [IDX_W-1:0] row;
  logic [LW-1:0]    inner_m1;
  logic [IDX_W-1:0] cols_m1;
  logic [LW-1:0]    l_cnt;
  logic [IDX_W-1:0] j_cnt;
  logic             l_end;
  logic             j_end;
  logic             start_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= CFG_W'(16);
      inner_len <= CFG_W'(16);
      b_cols    <= CFG_W'(16);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_A_ROWS:    a_rows    <= wr_data;
        REG_INNER_LEN: inner_len <= wr_data;
        REG_B_COLS:    b_cols    <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_c  = clamp_dim(a_rows, MAX_ROWS);
    inner_c = clamp_dim(inner_len, MAX_INNER);
    cols_c  = clamp_dim(b_cols, MAX_COLS);
    if (cols_c > 9'(RESULT_LIMIT)) begin
      cols_c = 9'(RESULT_LIMIT);
    end
  end

  // Loads write straight into the stores at accept
  always_comb begin
    we_a    = accept && (cmd == CMD_LOAD_A) && (int'(row_idx) < MAX_ROWS)
              && (int'(col_idx) < MAX_INNER);
    we_b    = accept && (cmd == CMD_LOAD_B) && (int'(row_idx) < MAX_INNER)
              && (int'(col_idx) < MAX_COLS);
    waddr_a = A_AW'(int'(row_idx) * MAX_INNER + int'(col_idx));
    waddr_b = B_AW'(int'(row_idx) * MAX_COLS + int'(col_idx));
    wdata   = elem_value;
  end

  assign start_row = accept && (cmd == CMD_ROW) && ({5'b0, row_idx} < rows_c);
  assign l_end     = (l_cnt == inner_m1);
  assign j_end     = (j_cnt == cols_m1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_row) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (l_end && j_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start_row) begin
      row      <= row_idx;
      inner_m1 <= LW'(inner_c - 9'd1);
      cols_m1  <= IDX_W'(cols_c - 9'd1);
      l_cnt    <= '0;
      j_cnt    <= '0;
    end else if (state == ST_RUN) begin
      // Advance inner index, wrap to the next column
      if (l_end) begin
        l_cnt <= '0;
        j_cnt <= j_cnt + 1'b1;
      end else begin
        l_cnt <= l_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    raddr_a      = A_AW'(int'(row) * MAX_INNER + int'(l_cnt));
    raddr_b      = B_AW'(int'(l_cnt) * MAX_COLS + int'(j_cnt));
    tag.valid    = (state == ST_RUN);
    tag.first    = (l_cnt == '0);
    tag.last     = l_end;
    tag.row_last = l_end && j_end;
    tag.row      = row;
    tag.col      = j_cnt;
  end

  assign running = (state == ST_RUN);

endmodule

// ===== sv/matrix_multiply.sv =====
// Top level of the matrix product block R = A x B: signed Q8.8 in, Q20.16 out.
//
// Commands enter on start/cmd/row_idx/col_idx/elem_value and are taken at a
// clock edge with start high and busy low. A load of A or B writes one
// element into its store in that cycle and leaves busy low, so loads can
// follow every cycle. A row request with row_idx below a_rows streams
// inner_len terms for each of b_cols columns through one shared
// multiply-accumulate fed from the two stores; one term per cycle, as each
// store has a single read port. A result follows its last term through the
// store read register, the product register and the accumulator.
// Each result shows on out_row/out_col/out_value/row_last for one cycle
// with valid high; the receiver cannot stall, and busy drops in the cycle
// the last result of the row shows. Configuration is to be written through
// wr_en/wr_idx/wr_data by the user only while busy is low; the block itself
// does not enforce it. Reset sets all three sizes to 16 and empties the
// pipeline; the stores keep no reset value.
module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_INNER = DEF_MAX_INNER,
  parameter int MAX_COLS  = DEF_MAX_COLS,
  localparam int A_DEPTH  = MAX_ROWS * MAX_INNER,
  localparam int B_DEPTH  = MAX_INNER * MAX_COLS,
  localparam int A_AW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1,
  localparam int B_AW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              cmd,
  input  logic [IDX_W-1:0]        row_idx,
  input  logic [IDX_W-1:0]        col_idx,
  input  logic signed [ELEM_W-1:0] elem_value,
  input  logic                    wr_en,
  input  logic [CFG_IDX_W-1:0]    wr_idx,
  input  logic [CFG_W-1:0]        wr_data,
  output logic                    valid,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    row_last
);

  logic              accept;
  logic              running;
  logic              pipe_busy;
  logic              we_a;
  logic              we_b;
  logic [A_AW-1:0]   waddr_a;
  logic [B_AW-1:0]   waddr_b;
  logic [ELEM_W-1:0] wdata;
  logic [A_AW-1:0]   raddr_a;
  logic [B_AW-1:0]   raddr_b;
  logic [ELEM_W-1:0] rdata_a;
  logic [ELEM_W-1:0] rdata_b;
  mm_tag_t           tag;

  assign busy   = running | pipe_busy;
  assign accept = start & ~busy;

  mm_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_INNER(MAX_INNER),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .row_idx   (row_idx),
    .col_idx   (col_idx),
    .elem_value(elem_value),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .we_a      (we_a),
    .waddr_a   (waddr_a),
    .we_b      (we_b),
    .waddr_b   (waddr_b),
    .wdata     (wdata),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .tag       (tag),
    .running   (running)
  );

  mm_store #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_INNER(MAX_INNER),
    .MAX_COLS (MAX_COLS)
  ) u_store (
    .clk    (clk),
    .we_a   (we_a),
    .waddr_a(waddr_a),
    .we_b   (we_b),
    .waddr_b(waddr_b),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  mm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .tag      (tag),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .pipe_busy(pipe_busy),
    .valid    (valid),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_value(out_value),
    .row_last (row_last)
  );

  // More results of the row are still in flight
  assert property (@(posedge clk) disable iff (rst) valid && !row_last |-> busy)
    else $error("busy low while a row still has results pending");

  // A new request cannot produce a result right after a row ends
  assert property (@(posedge clk) disable iff (rst) valid && row_last |=> !valid)
    else $error("result right after the end of a row");

  // Back-to-back results within a row step the column and keep the row
  assert property (@(posedge clk) disable iff (rst)
    valid && $past(valid) && !$past(row_last) |->
      (out_col == $past(out_col) + 1'b1) && (out_row == $past(out_row)))
    else $error("column sequence broken within a row");

endmodule

// ===== test/matrix_multiply_test.sv =====
// Self-checking testbench for the matrix product block: directed table, then random phases.
module matrix_multiply_test;
  import mm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_GAP    = 24;
  localparam int END_DRAIN   = 300;
  localparam int ITEM_TARGET = 110;

  typedef enum int {STEP_CFG, STEP_ITEM} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  op;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] val;
    int          n_typed;      // -1: use the product model, else typed result count
    longint      typed_value;
  } dir_step_t;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } product_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              cmd;
  logic [IDX_W-1:0]        row_idx;
  logic [IDX_W-1:0]        col_idx;
  logic signed [ELEM_W-1:0] elem_value;
  logic                    wr_en;
  logic [CFG_IDX_W-1:0]    wr_idx;
  logic [CFG_W-1:0]        wr_data;
  logic                    valid;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    row_last;

  matrix_multiply u_top (.*);

  // Model of the stores and size registers
  logic [15:0] mem_a [16][16];
  logic [15:0] mem_b [16][16];
  bit          seen_a [16][16];
  bit          seen_b [16][16];
  logic [4:0]  cfg_rows;
  logic [4:0]  cfg_inner;
  logic [4:0]  cfg_cols;

  product_t  pending_q[$];
  product_t  head;
  dir_step_t steps[$];
  int        errors;
  int        items_done;
  bit        steady;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int clamp_size(input logic [4:0] v, input int hi);
    if (v == 5'd0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int rows_used();
    return clamp_size(cfg_rows, DEF_MAX_ROWS);
  endfunction

  function automatic int inner_used();
    return clamp_size(cfg_inner, DEF_MAX_INNER);
  endfunction

  function automatic int cols_used();
    int c;
    c = clamp_size(cfg_cols, DEF_MAX_COLS);
    if (c > RESULT_LIMIT) c = RESULT_LIMIT;
    return c;
  endfunction

  // Apply one item to the model; queue the row products when asked
  function automatic void apply_item(input logic [1:0] op, input logic [3:0] rr,
                                     input logic [3:0] cc, input logic [15:0] vv,
                                     input bit push);
    longint   acc;
    product_t p;
    case (op)
      CMD_LOAD_A: begin
        mem_a[rr][cc] = vv;
        seen_a[rr][cc] = 1'b1;
      end
      CMD_LOAD_B: begin
        mem_b[rr][cc] = vv;
        seen_b[rr][cc] = 1'b1;
      end
      CMD_ROW: begin
        if (push && int'(rr) < rows_used()) begin
          for (int j = 0; j < cols_used(); j++) begin
            acc = 0;
            for (int l = 0; l < inner_used(); l++)
              acc += longint'($signed(mem_a[rr][l])) * longint'($signed(mem_b[l][j]));
            p.row   = rr;
            p.col   = j[3:0];
            p.value = acc[35:0];
            p.last  = (j + 1 == cols_used());
            pending_q.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 90) return $urandom_range(1, 5);
    if (p < 98) return $urandom_range(6, 40);
    return $urandom_range(41, 300);
  endfunction

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Wide picks reach the saturating values; narrow ones keep the row small
  function automatic logic [4:0] pick_size(input bit wide);
    int p;
    p = $urandom_range(9);
    if (p == 0) return 5'd0;
    if (wide && p == 1) return 5'($urandom_range(17, 31));
    if (wide && p == 2) return 5'd16;
    if (wide && p < 5) return 5'($urandom_range(5, 15));
    return 5'($urandom_range(1, 4));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [3:0] rr, input logic [3:0] cc,
                           input logic [15:0] vv, input bit push);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    cmd        <= op;
    row_idx    <= rr;
    col_idx    <= cc;
    elem_value <= vv;
    do @(posedge clk); while (busy);
    items_done++;
    apply_item(op, rr, cc, vv, push);
  endtask

  // Drop start and let the pipeline empty before touching the sizes
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0 || busy) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] data);
    @(negedge clk);
    wr_en   <= 1'b1;
    wr_idx  <= idx;
    wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_A_ROWS:    cfg_rows = data;
      REG_INNER_LEN: cfg_inner = data;
      REG_B_COLS:    cfg_cols = data;
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Load the unloaded elements a request of row rr reads; overwrite all with fa/fb when forced
  task automatic fill_row(input logic [3:0] rr, input bit force_all,
                          input logic [15:0] fa, input logic [15:0] fb);
    for (int l = 0; l < inner_used(); l++) begin
      if (force_all || !seen_a[rr][l])
        send_item(CMD_LOAD_A, rr, l[3:0], force_all ? fa : pick_elem(), 1'b1);
      for (int j = 0; j < cols_used(); j++)
        if (force_all || !seen_b[l][j])
          send_item(CMD_LOAD_B, l[3:0], j[3:0], force_all ? fb : pick_elem(), 1'b1);
    end
  endtask

  task automatic add_step(input step_kind_t kind, input logic [1:0] op, input logic [3:0] rr,
                          input logic [3:0] cc, input logic [15:0] vv, input int n,
                          input longint tv);
    dir_step_t s;
    s.kind = kind;
    s.op = op;
    s.row = rr;
    s.col = cc;
    s.val = vv;
    s.n_typed = n;
    s.typed_value = tv;
    steps.push_back(s);
  endtask

  always @(posedge clk) begin
    if (!rst && valid) begin
      if (pending_q.size() == 0) begin
        report_error($sformatf("unexpected result row %0d col %0d value %0d",
                               out_row, out_col, out_value));
      end else begin
        head = pending_q.pop_front();
        if (out_row !== head.row || out_col !== head.col || out_value !== head.value ||
            row_last !== head.last)
          report_error($sformatf("got r%0d c%0d v%0d l%0d, want r%0d c%0d v%0d l%0d",
                                 out_row, out_col, out_value, row_last,
                                 head.row, head.col, head.value, head.last));
      end
    end
  end

  initial begin
    #16_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int        nseq;
    int        p;
    logic [3:0] rr;
    logic [3:0] cc;
    product_t  tp;

    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_LOAD_A;
    row_idx = '0;
    col_idx = '0;
    elem_value = '0;
    wr_en = 1'b0;
    wr_idx = REG_A_ROWS;
    wr_data = '0;
    errors = 0;
    items_done = 0;
    steady = 1'b0;
    cfg_rows = 5'd16;
    cfg_inner = 5'd16;
    cfg_cols = 5'd16;
    foreach (seen_a[i, j]) begin
      seen_a[i][j] = 1'b0;
      seen_b[i][j] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single-element products at the value extremes
    add_step(STEP_CFG, REG_A_ROWS, 0, 0, 16'd1, 0, 0);
    add_step(STEP_CFG, REG_INNER_LEN, 0, 0, 16'd1, 0, 0);
    add_step(STEP_CFG, REG_B_COLS, 0, 0, 16'd1, 0, 0);
    add_step(STEP_ITEM, CMD_LOAD_A, 0, 0, 16'h8000, 0, 0);
    add_step(STEP_ITEM, CMD_LOAD_B, 0, 0, 16'h8000, 0, 0);
    add_step(STEP_ITEM, CMD_ROW, 0, 0, 16'h0000, 1, 64'sd1073741824);
    add_step(STEP_ITEM, CMD_LOAD_B, 0, 0, 16'h7FFF, 0, 0);
    add_step(STEP_ITEM, CMD_ROW, 0, 0, 16'h0000, 1, -64'sd1073709056);
    add_step(STEP_ITEM, CMD_LOAD_A, 0, 0, 16'h7FFF, 0, 0);
    add_step(STEP_ITEM, CMD_ROW, 0, 0, 16'h0000, 1, 64'sd1073676289);
    // Row past a_rows and the unused command give nothing
    add_step(STEP_ITEM, CMD_ROW, 1, 0, 16'h0000, 0, 0);
    add_step(STEP_ITEM, CMD_UNUSED, 0, 0, 16'h0000, 0, 0);
    add_step(STEP_ITEM, CMD_ROW, 0, 0, 16'h0000, 1, 64'sd1073676289);
    // Zero sizes count as one
    add_step(STEP_CFG, REG_A_ROWS, 0, 0, 16'd0, 0, 0);
    add_step(STEP_CFG, REG_INNER_LEN, 0, 0, 16'd0, 0, 0);
    add_step(STEP_CFG, REG_B_COLS, 0, 0, 16'd0, 0, 0);
    add_step(STEP_ITEM, CMD_ROW, 0, 15, 16'hFFFF, 1, 64'sd1073676289);
    add_step(STEP_ITEM, CMD_LOAD_A, 15, 15, 16'h8000, 0, 0);
    add_step(STEP_ITEM, CMD_LOAD_B, 15, 15, 16'h7FFF, 0, 0);
    // Oversized values saturate to the store size
    add_step(STEP_CFG, REG_A_ROWS, 0, 0, 16'd31, 0, 0);
    add_step(STEP_CFG, REG_INNER_LEN, 0, 0, 16'd31, 0, 0);
    add_step(STEP_ITEM, CMD_ROW, 15, 0, 16'h0000, -1, 0);
    add_step(STEP_CFG, REG_INNER_LEN, 0, 0, 16'd1, 0, 0);
    add_step(STEP_CFG, REG_B_COLS, 0, 0, 16'd31, 0, 0);
    add_step(STEP_ITEM, CMD_ROW, 15, 0, 16'h0000, -1, 0);
    add_step(STEP_ITEM, CMD_ROW, 0, 0, 16'h0000, -1, 0);
    add_step(STEP_CFG, REG_INNER_LEN, 0, 0, 16'd2, 0, 0);
    add_step(STEP_CFG, REG_B_COLS, 0, 0, 16'd3, 0, 0);
    add_step(STEP_ITEM, CMD_ROW, 9, 0, 16'h0000, -1, 0);

    foreach (steps[i]) begin
      if (steps[i].kind == STEP_CFG) begin
        wait_idle();
        write_reg(steps[i].op, steps[i].val[4:0]);
      end else begin
        if (steps[i].op == CMD_ROW && steps[i].n_typed < 0)
          fill_row(steps[i].row, 1'b0, 16'h0000, 16'h0000);
        send_item(steps[i].op, steps[i].row, steps[i].col, steps[i].val,
                  steps[i].n_typed < 0);
        if (steps[i].n_typed == 1) begin
          tp.row = steps[i].row;
          tp.col = '0;
          tp.value = steps[i].typed_value[35:0];
          tp.last = 1'b1;
          pending_q.push_back(tp);
        end
      end
    end

    while (items_done < ITEM_TARGET) begin
      wait_idle();
      if ($urandom_range(9) < 7) write_reg(REG_A_ROWS, pick_size(1'b1));
      if ($urandom_range(9) < 7) write_reg(REG_INNER_LEN, pick_size(1'b0));
      if ($urandom_range(9) < 7) write_reg(REG_B_COLS, pick_size(1'b0));
      steady = ($urandom_range(3) == 0);
      nseq = $urandom_range(1, 4);
      repeat (nseq) begin
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(9) < 7) begin
            rr = 4'($urandom_range(0, 15) % inner_used());
            cc = 4'($urandom_range(0, 15) % cols_used());
          end else begin
            rr = 4'($urandom);
            cc = 4'($urandom);
          end
          send_item($urandom_range(1) ? CMD_LOAD_B : CMD_LOAD_A, rr, cc, pick_elem(), 1'b1);
        end
        p = $urandom_range(19);
        if (p == 0) begin
          send_item(CMD_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom), 1'b1);
        end else if (p == 1 && rows_used() < 16) begin
          send_item(CMD_ROW, 4'($urandom_range(rows_used(), 15)), 4'($urandom),
                    16'($urandom), 1'b1);
        end else begin
          rr = 4'($urandom_range(0, rows_used() - 1));
          // Occasionally drive every term to an extreme to reach the widest sums
          if ($urandom_range(9) == 0)
            fill_row(rr, 1'b1, $urandom_range(1) ? 16'h8000 : 16'h7FFF,
                     $urandom_range(1) ? 16'h8000 : 16'h7FFF);
          else
            fill_row(rr, 1'b0, 16'h0000, 16'h0000);
          send_item(CMD_ROW, rr, 4'($urandom), 16'($urandom), 1'b1);
        end
      end
    end

    wait_idle();
    repeat (END_DRAIN) @(posedge clk);
    if (pending_q.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_q.size()));
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mm_pkg.sv
sv/mm_store.sv
sv/mm_mac.sv
sv/mm_ctrl.sv
sv/matrix_multiply.sv
test/matrix_multiply_test.sv
